### sv/csi_pkg.sv
// Shared types, constants and cosine weight tables for the curve select interpolator.
// No dependencies; imported by csi_weight and curve_select_interpolator.
package csi_pkg;

    localparam int FRAC_BITS = 16;
    localparam int COS_DEPTH = 256;
    localparam int COS_IDX_W = $clog2(COS_DEPTH);
    localparam int VAL_W     = 32;
    localparam int W_W       = FRAC_BITS + 1;
    localparam int MODE_W    = 3;
    localparam int WEIGHT_LAT = 4;

    localparam logic [W_W-1:0] ONE  = W_W'(1) << FRAC_BITS;
    localparam logic [W_W-1:0] HALF = W_W'(1) << (FRAC_BITS - 1);

    localparam logic [MODE_W-1:0] MODE_LINEAR    = 3'd0;
    localparam logic [MODE_W-1:0] MODE_COSINE    = 3'd1;
    localparam logic [MODE_W-1:0] MODE_CUBIC     = 3'd2;
    localparam logic [MODE_W-1:0] MODE_QUINTIC   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_QUARTIC   = 3'd4;
    localparam logic [MODE_W-1:0] MODE_QUADRATIC = 3'd5;

    typedef logic [MODE_W-1:0] mode_t;
    typedef logic [W_W-1:0]    weight_t;

    typedef struct packed {
        logic [W_W-1:0]          blend_position;
        logic signed [VAL_W-1:0] start_value;
        logic signed [VAL_W-1:0] end_value;
    } csi_in_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] blended_value;
        logic                    saturated;
    } csi_out_t;

    typedef struct packed {
        logic    valid;
        mode_t   mode;
        weight_t t;
    } csi_blend_t;

    typedef struct packed {
        logic    valid;
        mode_t   mode;
        weight_t wa;
        weight_t wb;
    } csi_weight_t;

    typedef logic [COS_DEPTH-1:0][W_W-1:0] cos_row_t;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [7:0][63:0] Taylor_Div = {
        64'd210, 64'd156, 64'd110, 64'd72, 64'd42, 64'd20, 64'd6, 64'd1
    };

    function automatic weight_t cos_entry(input int unsigned idx);
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic [63:0]        sq;
        logic [63:0]        w;
        logic signed [63:0] s;
        if (idx == 0)
        begin
            return '0;
        end
        if (idx >= COS_DEPTH)
        begin
            return ONE;
        end
        x    = (HALF_PI_Q30 * 64'(idx)) / COS_DEPTH;
        x2   = (x * x) >> 30;
        term = x;
        s    = $signed(x);
        for (int k = 1; k <= 7; k++)
        begin
            term = ((term * x2) >> 30) / Taylor_Div[k];
            if (k % 2 == 1)
            begin
                s = s - $signed(term);
            end
            else
            begin
                s = s + $signed(term);
            end
        end
        if (s < 0)
        begin
            s = '0;
        end
        sq = $unsigned(s) * $unsigned(s);
        w  = (sq + (64'd1 << (59 - FRAC_BITS))) >> (60 - FRAC_BITS);
        if (w > 64'(ONE))
        begin
            w = 64'(ONE);
        end
        return w[W_W-1:0];
    endfunction

    function automatic cos_row_t cos_row(input int unsigned offset);
        cos_row_t row;
        for (int unsigned i = 0; i < COS_DEPTH; i++)
        begin
            row[i] = cos_entry(i + offset);
        end
        return row;
    endfunction

    // Entry i and entry i+1 of the squared sine curve, one read each per item.
    localparam cos_row_t COS_LO_TABLE = cos_row(0);
    localparam cos_row_t COS_HI_TABLE = cos_row(1);

endpackage

### sv/curve_select_interpolator.sv
// Top level of the curve select interpolator: input capture, endpoint products,
// rounding and saturation. Depends on csi_pkg and csi_weight.
//
// One item is taken per clock whenever start is high; busy is always low, and the receiver
// cannot hold results off. Each result is driven on result with done high for exactly one
// cycle, in order, after the item has passed seven register stages: input capture, four
// weight stages (powers of t, cosine interpolation, fifth power, curve select), one stage
// for the two endpoint multiplies and the result register after the sum and saturation.
// cfg_ready is high only while no item is in flight and start is low, so curve_mode
// changes between items only.
module curve_select_interpolator
    import csi_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    input  csi_in_t  item,
    output logic     done,
    output csi_out_t result,
    input  logic     cfg_valid,
    output logic     cfg_ready,
    input  mode_t    cfg_data
);

    localparam int MUL_W = VAL_W + W_W + 1;
    localparam int SUM_W = MUL_W + 1;
    localparam int R_W   = SUM_W - FRAC_BITS;

    localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

    mode_t                   mode_reg;
    logic                    s0_valid_reg;
    mode_t                   s0_mode_reg;
    weight_t                 s0_t_reg;
    logic signed [VAL_W-1:0] s0_a_reg, s0_b_reg;
    weight_t                 s0_t_next;

    logic signed [VAL_W-1:0] a_dly_reg [WEIGHT_LAT];
    logic signed [VAL_W-1:0] b_dly_reg [WEIGHT_LAT];

    csi_blend_t  blend;
    csi_weight_t weight;
    logic        weight_active;

    logic                    s5_valid_reg;
    logic signed [MUL_W-1:0] s5_pa_reg, s5_pb_reg;

    logic                    done_reg;
    csi_out_t                result_reg;
    logic signed [SUM_W-1:0] sum;
    logic signed [R_W-1:0]   rounded;
    logic                    clip;
    csi_out_t                result_next;

    assign busy      = 1'b0;
    assign cfg_ready = !(start | s0_valid_reg | weight_active | s5_valid_reg | done_reg);

    always_comb
    begin
        s0_t_next = (item.blend_position > ONE) ? ONE : item.blend_position;
    end

    assign blend.valid = s0_valid_reg;
    assign blend.mode  = s0_mode_reg;
    assign blend.t     = s0_t_reg;

    csi_weight u_weight (
        .clk    (clk),
        .rst_n  (rst_n),
        .blend  (blend),
        .weight (weight),
        .active (weight_active)
    );

    always_comb
    begin
        sum     = SUM_W'(s5_pa_reg) + SUM_W'(s5_pb_reg) + $signed(SUM_W'(HALF));
        rounded = R_W'(sum >>> FRAC_BITS);
        clip    = !((&rounded[R_W-1:VAL_W-1]) || !(|rounded[R_W-1:VAL_W-1]));
        result_next.saturated = clip;
        if (clip)
        begin
            result_next.blended_value = rounded[R_W-1] ? VAL_MIN : VAL_MAX;
        end
        else
        begin
            result_next.blended_value = rounded[VAL_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_LINEAR;
            s0_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                mode_reg <= cfg_data;
            end
            s0_valid_reg <= start && !busy;
            s5_valid_reg <= weight.valid;
            done_reg     <= s5_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s0_mode_reg  <= mode_reg;
        s0_t_reg     <= s0_t_next;
        s0_a_reg     <= item.start_value;
        s0_b_reg     <= item.end_value;
        a_dly_reg[0] <= s0_a_reg;
        b_dly_reg[0] <= s0_b_reg;
        for (int i = 1; i < WEIGHT_LAT; i++)
        begin
            a_dly_reg[i] <= a_dly_reg[i-1];
            b_dly_reg[i] <= b_dly_reg[i-1];
        end
        s5_pa_reg  <= MUL_W'(a_dly_reg[WEIGHT_LAT-1]) * $signed(MUL_W'(weight.wa));
        s5_pb_reg  <= MUL_W'(b_dly_reg[WEIGHT_LAT-1]) * $signed(MUL_W'(weight.wb));
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

    a_fixed_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##7 done)
        else $error("result missing seven cycles after transfer");

    a_clip_extreme: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.saturated)
        |-> (result.blended_value == VAL_MAX || result.blended_value == VAL_MIN))
        else $error("saturated result not at a range limit");

    a_mode_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s0_valid_reg |=> $stable(mode_reg))
        else $error("curve mode changed with an item in flight");

endmodule

### sv/csi_weight.sv
// Four-stage weight pipeline: powers of t, cosine lookup, curve selection.
// Depends on csi_pkg for formats, mode codes and the cosine tables.
module csi_weight
    import csi_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  csi_blend_t  blend,
    output csi_weight_t weight,
    output logic        active
);

    localparam int PROD_W  = 2 * W_W;
    localparam int POLY_W  = W_W + 5;
    localparam int CPROD_W = W_W + FRAC_BITS + 2;
    localparam int P_W     = W_W + COS_IDX_W;

    localparam logic signed [POLY_W-1:0] K2  = POLY_W'(2);
    localparam logic signed [POLY_W-1:0] K3  = POLY_W'(3);
    localparam logic signed [POLY_W-1:0] K6  = POLY_W'(6);
    localparam logic signed [POLY_W-1:0] K10 = POLY_W'(10);
    localparam logic signed [POLY_W-1:0] K15 = POLY_W'(15);

    function automatic weight_t rnd_mul(input weight_t x, input weight_t y);
        logic [PROD_W-1:0] prod;
        prod = PROD_W'(x) * PROD_W'(y) + PROD_W'(HALF);
        return prod[FRAC_BITS +: W_W];
    endfunction

    function automatic weight_t clamp_w(input logic signed [POLY_W-1:0] v);
        if (v < 0)
        begin
            return '0;
        end
        if (v > $signed(POLY_W'(ONE)))
        begin
            return ONE;
        end
        return v[W_W-1:0];
    endfunction

    // stage 1
    logic                  s1_valid_reg;
    mode_t                 s1_mode_reg;
    weight_t               s1_t_reg, s1_p2_reg, s1_q_reg, s1_e0_reg, s1_e1_reg;
    logic [FRAC_BITS-1:0]  s1_frac_reg;
    logic                  s1_full_reg;
    logic [P_W-1:0]        cos_pos;
    weight_t               s1_p2_next, s1_q_next;

    // stage 2
    logic    s2_valid_reg;
    mode_t   s2_mode_reg;
    weight_t s2_t_reg, s2_p2_reg, s2_p3_reg, s2_p4_reg, s2_q_reg, s2_cw_reg;
    logic signed [W_W:0]       cos_diff;
    logic signed [CPROD_W-1:0] cos_prod;
    weight_t s2_cw_next;

    // stage 3
    logic    s3_valid_reg;
    mode_t   s3_mode_reg;
    weight_t s3_t_reg, s3_p2_reg, s3_p3_reg, s3_p4_reg, s3_p5_reg, s3_q_reg, s3_cw_reg;

    // stage 4
    logic    s4_valid_reg;
    mode_t   s4_mode_reg;
    weight_t s4_wa_reg, s4_wb_reg;
    weight_t w_sel, s4_wa_next, s4_wb_next;
    logic signed [POLY_W-1:0] p2s, p3s, p4s, p5s;

    always_comb
    begin
        s1_p2_next = rnd_mul(blend.t, blend.t);
        s1_q_next  = rnd_mul(ONE - blend.t, ONE - blend.t);
        cos_pos    = P_W'(blend.t) * P_W'(COS_DEPTH);
    end

    always_comb
    begin
        cos_diff   = $signed({1'b0, s1_e1_reg}) - $signed({1'b0, s1_e0_reg});
        cos_prod   = CPROD_W'(cos_diff) * $signed(CPROD_W'(s1_frac_reg))
                     + $signed(CPROD_W'(HALF));
        s2_cw_next = clamp_w($signed(POLY_W'(s1_e0_reg))
                             + POLY_W'(cos_prod >>> FRAC_BITS));
        if (s1_full_reg)
        begin
            s2_cw_next = ONE;
        end
    end

    always_comb
    begin
        p2s = $signed(POLY_W'(s3_p2_reg));
        p3s = $signed(POLY_W'(s3_p3_reg));
        p4s = $signed(POLY_W'(s3_p4_reg));
        p5s = $signed(POLY_W'(s3_p5_reg));
        case (s3_mode_reg)
            MODE_COSINE:  w_sel = s3_cw_reg;
            MODE_CUBIC:   w_sel = clamp_w(K3 * p2s - K2 * p3s);
            MODE_QUINTIC: w_sel = clamp_w(K6 * p5s - K15 * p4s + K10 * p3s);
            MODE_QUARTIC: w_sel = s3_p4_reg;
            default:      w_sel = s3_t_reg;
        endcase
        if (s3_mode_reg == MODE_QUADRATIC)
        begin
            s4_wa_next = s3_q_reg;
            s4_wb_next = s3_p2_reg;
        end
        else
        begin
            s4_wa_next = ONE - w_sel;
            s4_wb_next = w_sel;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= blend.valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_mode_reg <= blend.mode;
        s1_t_reg    <= blend.t;
        s1_p2_reg   <= s1_p2_next;
        s1_q_reg    <= s1_q_next;
        s1_e0_reg   <= COS_LO_TABLE[cos_pos[FRAC_BITS +: COS_IDX_W]];
        s1_e1_reg   <= COS_HI_TABLE[cos_pos[FRAC_BITS +: COS_IDX_W]];
        s1_frac_reg <= cos_pos[FRAC_BITS-1:0];
        s1_full_reg <= (blend.t == ONE);

        s2_mode_reg <= s1_mode_reg;
        s2_t_reg    <= s1_t_reg;
        s2_p2_reg   <= s1_p2_reg;
        s2_p3_reg   <= rnd_mul(s1_p2_reg, s1_t_reg);
        s2_p4_reg   <= rnd_mul(s1_p2_reg, s1_p2_reg);
        s2_q_reg    <= s1_q_reg;
        s2_cw_reg   <= s2_cw_next;

        s3_mode_reg <= s2_mode_reg;
        s3_t_reg    <= s2_t_reg;
        s3_p2_reg   <= s2_p2_reg;
        s3_p3_reg   <= s2_p3_reg;
        s3_p4_reg   <= s2_p4_reg;
        s3_p5_reg   <= rnd_mul(s2_p4_reg, s2_t_reg);
        s3_q_reg    <= s2_q_reg;
        s3_cw_reg   <= s2_cw_reg;

        s4_mode_reg <= s3_mode_reg;
        s4_wa_reg   <= s4_wa_next;
        s4_wb_reg   <= s4_wb_next;
    end

    assign weight.valid = s4_valid_reg;
    assign weight.mode  = s4_mode_reg;
    assign weight.wa    = s4_wa_reg;
    assign weight.wb    = s4_wb_reg;
    assign active       = s1_valid_reg | s2_valid_reg | s3_valid_reg | s4_valid_reg;

    a_weights_complement: assert property (@(posedge clk) disable iff (!rst_n)
        (s4_valid_reg && s4_mode_reg != MODE_QUADRATIC)
        |-> ((W_W+1)'(s4_wa_reg) + (W_W+1)'(s4_wb_reg) == (W_W+1)'(ONE)))
        else $error("curve weights do not sum to one");

    a_weights_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        s4_valid_reg |-> (s4_wa_reg <= ONE && s4_wb_reg <= ONE))
        else $error("weight above one");

endmodule
